// ===== hw/rtl/bgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bgcd_pkg
// Shared widths, register codes and the LiPo discharge curve for the battery
// gauge with charge detection.
// ----------------------------------------------------------------------------
package bgcd_pkg;

  localparam int TAP_W      = 12;
  localparam int SUM_W      = 16;
  localparam int MV_W       = 13;
  localparam int PCT_W      = 7;
  localparam int BUCKET_W   = 4;
  localparam int SLOPE_W    = 14;
  localparam int DELTA_W    = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int CURVE_PTS = 16;
  localparam int SEG_W     = 4;

  // Breakpoints from full (100 %) down to empty (0 %).
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_PTS] = '{
    13'd4200, 13'd4150, 13'd4100, 13'd4050, 13'd4000, 13'd3950, 13'd3900, 13'd3850,
    13'd3800, 13'd3750, 13'd3700, 13'd3650, 13'd3600, 13'd3500, 13'd3400, 13'd3300
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_PTS] = '{
    7'd100, 7'd95, 7'd90, 7'd82, 7'd75, 7'd65, 7'd55, 7'd45,
    7'd35,  7'd25, 7'd18, 7'd12, 7'd8,  7'd4,  7'd1,  7'd0
  };

  localparam logic [MV_W-1:0]  RST_ENTER_MV = 13'd4080;
  localparam logic [MV_W-1:0]  RST_EXIT_MV  = 13'd3980;
  localparam logic [DELTA_W-1:0] RST_RISE_MV = 10'd15;
  localparam logic [DELTA_W-1:0] RST_FALL_MV = 10'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTER = 2'd0,
    CFG_EXIT  = 2'd1,
    CFG_RISE  = 2'd2,
    CFG_FALL  = 2'd3
  } cfg_reg_t;

  // Tens bucket of a percentage in 0..100, by parallel compares.
  function automatic logic [BUCKET_W-1:0] pct_bucket(input logic [PCT_W-1:0] pct);
    logic [BUCKET_W-1:0] b;
    b = '0;
    for (int k = 1; k <= 10; k++) begin
      if (pct >= PCT_W'(10 * k)) begin
        b = b + BUCKET_W'(1);
      end
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/bgcd_in_if.sv =====
// ----------------------------------------------------------------------------
// bgcd_in_if
// Reading channel: one tap voltage word per handshake.
// ----------------------------------------------------------------------------
interface bgcd_in_if;
  import bgcd_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAP_W-1:0] tap_mv;
  logic             cold_start;

  modport source (output valid, output tap_mv, output cold_start, input ready);
  modport sink   (input valid, input tap_mv, input cold_start, output ready);
endinterface

// ===== hw/rtl/bgcd_out_if.sv =====
// ----------------------------------------------------------------------------
// bgcd_out_if
// Result channel: one gauge word per completed batch.
// ----------------------------------------------------------------------------
interface bgcd_out_if;
  import bgcd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [MV_W-1:0]           battery_mv;
  logic [PCT_W-1:0]          percent;
  logic [BUCKET_W-1:0]       bucket;
  logic                      charging;
  logic signed [SLOPE_W-1:0] slope_mv;

  modport source (output valid, output battery_mv, output percent, output bucket,
                  output charging, output slope_mv, input ready);
  modport sink   (input valid, input battery_mv, input percent, input bucket,
                  input charging, input slope_mv, output ready);
endinterface

// ===== hw/rtl/bgcd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bgcd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bgcd_cfg_if;
  import bgcd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/battery_gauge_charge_detect.sv =====
// ----------------------------------------------------------------------------
// battery_gauge_charge_detect
// Sums batches of tap readings, maps the battery voltage onto a LiPo curve
// and keeps a charging latch driven by slope and voltage thresholds.
// ----------------------------------------------------------------------------
// Throughput: one reading per cycle, but a reading that closes a batch is held
// while the scaling stage cannot take it; the result then reaches the output register.
// The four stages (input register, voltage scaling multiply, curve segment and
// latch update, segment interpolation) each hand over through a valid bit, so
// bubbles collapse; readings that do not close a batch enter while results wait.
// Reset clears the stage valids, the batch accumulator, the previous voltage
// and the latch, and loads the register defaults; configuration is always ready.
module battery_gauge_charge_detect #(
  parameter int SAMPLES_PER_BATCH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  bgcd_in_if.sink           in_if,
  bgcd_out_if.source        out_if,
  bgcd_cfg_if.sink          cfg_if
);
  import bgcd_pkg::*;

  localparam int CNT_W   = (SAMPLES_PER_BATCH > 1) ? $clog2(SAMPLES_PER_BATCH) : 1;
  localparam int NUM_W   = SUM_W + 1;
  localparam int DIV_SH  = NUM_W + 5;
  localparam int DIV_M_W = DIV_SH + 1;
  localparam longint unsigned DIV_M =
    ((64'd1 << DIV_SH) + SAMPLES_PER_BATCH - 1) / SAMPLES_PER_BATCH;
  localparam int PROD_W  = NUM_W + DIV_M_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_BATCH - 1);

  // Configuration registers.
  logic [MV_W-1:0]    enter_mv_r;
  logic [MV_W-1:0]    exit_mv_r;
  logic [DELTA_W-1:0] rise_mv_r;
  logic [DELTA_W-1:0] fall_mv_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_mv_r <= RST_ENTER_MV;
      exit_mv_r  <= RST_EXIT_MV;
      rise_mv_r  <= RST_RISE_MV;
      fall_mv_r  <= RST_FALL_MV;
    end else if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        CFG_ENTER: enter_mv_r <= cfg_if.data;
        CFG_EXIT:  exit_mv_r  <= cfg_if.data;
        CFG_RISE:  rise_mv_r  <= cfg_if.data[DELTA_W-1:0];
        CFG_FALL:  fall_mv_r  <= cfg_if.data[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and handshake chain.
  logic v1_r, v2_r, v3_r, v4_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic s1_go, s2_go, s3_go, s4_go;
  logic end1;

  assign rdy_out = !out_v_r || out_if.ready;
  assign rdy4    = !v4_r || rdy_out;
  assign rdy3    = !v3_r || rdy4;
  assign rdy2    = !v2_r || rdy3;
  assign s4_go   = v4_r && rdy_out;
  assign s3_go   = v3_r && rdy4;
  assign s2_go   = v2_r && rdy3;
  // A reading that does not close a batch only feeds the accumulator.
  assign s1_go   = v1_r && (!end1 || rdy2);
  assign rdy1    = !v1_r || s1_go;
  assign in_if.ready = rdy1;

  // Stage 1: input register and batch accumulator.
  logic [TAP_W-1:0] tap1_r;
  logic             cold1_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_nxt;

  assign end1    = (cnt_r == LAST_CNT);
  assign sum_nxt = sum_r + SUM_W'(tap1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (rdy1) begin
        v1_r <= in_if.valid;
      end
      if (s1_go) begin
        if (end1) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      tap1_r  <= in_if.tap_mv;
      cold1_r <= in_if.cold_start;
    end
  end

  // Stage 2: battery voltage = 2 * sum / batch size, by reciprocal multiply.
  logic [SUM_W-1:0]  sum2_r;
  logic              cold2_r;
  logic [PROD_W-1:0] scale_prod;

  assign scale_prod = PROD_W'({sum2_r, 1'b0}) * PROD_W'(DIV_M_W'(DIV_M));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= s1_go && end1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sum2_r  <= sum_nxt;
      cold2_r <= cold1_r;
    end
  end

  // Stage 3: curve segment, interpolation product and charging latch.
  logic [MV_W-1:0]           mv3_r;
  logic                      cold3_r;
  logic [MV_W-1:0]           prev_mv_r;
  logic                      latch_r;
  logic [SEG_W-1:0]          seg;
  logic                      sat_hi, sat_lo;
  logic [MV_W-1:0]           seg_off;
  logic [PCT_W-1:0]          base3;
  logic [SUM_W-6:0]          prod3;
  logic                      wide3;
  logic signed [SLOPE_W:0]   slope_w;
  logic signed [SLOPE_W:0]   fall_sum;
  logic                      latch_nxt;

  always_comb begin
    seg = '0;
    for (int i = 0; i < CURVE_PTS - 1; i++) begin
      if (mv3_r <= CURVE_MV[i] && mv3_r > CURVE_MV[i+1]) begin
        seg = SEG_W'(i);
      end
    end
  end

  assign sat_hi  = (mv3_r >= CURVE_MV[0]);
  assign sat_lo  = (mv3_r <= CURVE_MV[CURVE_PTS-1]);
  assign seg_off = mv3_r - CURVE_MV[seg + SEG_W'(1)];
  assign wide3   = ((CURVE_MV[seg] - CURVE_MV[seg + SEG_W'(1)]) == MV_W'(100));

  always_comb begin
    if (sat_hi) begin
      base3 = CURVE_PCT[0];
      prod3 = '0;
    end else if (sat_lo) begin
      base3 = CURVE_PCT[CURVE_PTS-1];
      prod3 = '0;
    end else begin
      base3 = CURVE_PCT[seg + SEG_W'(1)];
      // Offset is at most 100 and the percent step below 11, so 11 bits hold it.
      prod3 = (SUM_W-5)'(seg_off[6:0]) *
              (SUM_W-5)'(CURVE_PCT[seg] - CURVE_PCT[seg + SEG_W'(1)]);
    end
  end

  assign slope_w  = $signed({2'b00, mv3_r}) - $signed({2'b00, prev_mv_r});
  assign fall_sum = slope_w + $signed({{(SLOPE_W+1-DELTA_W){1'b0}}, fall_mv_r});

  always_comb begin
    latch_nxt = latch_r;
    if (cold3_r) begin
      latch_nxt = (mv3_r >= enter_mv_r);
    end else if (slope_w >= $signed({{(SLOPE_W+1-DELTA_W){1'b0}}, rise_mv_r})) begin
      latch_nxt = 1'b1;
    end else if (fall_sum <= 0) begin
      latch_nxt = 1'b0;
    end else if (mv3_r >= enter_mv_r) begin
      latch_nxt = 1'b1;
    end else if (mv3_r <= exit_mv_r) begin
      latch_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r      <= 1'b0;
      prev_mv_r <= '0;
      latch_r   <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= s2_go;
      end
      if (s3_go) begin
        prev_mv_r <= mv3_r;
        latch_r   <= latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mv3_r   <= scale_prod[DIV_SH +: MV_W];
      cold3_r <= cold2_r;
    end
  end

  // Stage 4: divide the product by the segment width (50 or 100 mV).
  logic [MV_W-1:0]           mv4_r;
  logic [PCT_W-1:0]          base4_r;
  logic [SUM_W-6:0]          prod4_r;
  logic                      wide4_r;
  logic                      latch4_r;
  logic signed [SLOPE_W-1:0] slope4_r;
  logic [20:0]               q_prod;
  logic [4:0]                q50;
  logic [4:0]                q;
  logic [PCT_W-1:0]          pct4;

  // 1311 / 65536 is exact for floor(p / 50) over p < 1000.
  assign q_prod = 21'(prod4_r) * 21'd1311;
  assign q50    = q_prod[20:16];
  assign q      = wide4_r ? (q50 >> 1) : q50;
  assign pct4   = base4_r + PCT_W'(q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= s3_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      mv4_r    <= mv3_r;
      base4_r  <= base3;
      prod4_r  <= prod3;
      wide4_r  <= wide3;
      latch4_r <= latch_nxt;
      slope4_r <= cold3_r ? '0 : slope_w[SLOPE_W-1:0];
    end
  end

  // Output register.
  logic [MV_W-1:0]           out_mv_r;
  logic [PCT_W-1:0]          out_pct_r;
  logic [BUCKET_W-1:0]       out_bucket_r;
  logic                      out_chg_r;
  logic signed [SLOPE_W-1:0] out_slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_out) begin
      out_v_r <= s4_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_mv_r     <= mv4_r;
      out_pct_r    <= pct4;
      out_bucket_r <= pct_bucket(pct4);
      out_chg_r    <= latch4_r;
      out_slope_r  <= slope4_r;
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.battery_mv = out_mv_r;
  assign out_if.percent    = out_pct_r;
  assign out_if.bucket     = out_bucket_r;
  assign out_if.charging   = out_chg_r;
  assign out_if.slope_mv   = out_slope_r;

  // Checks.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_CNT)
    else $error("batch counter passed the batch size");

  a_batch_end_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && end1) |=> v2_r)
    else $error("closing reading did not reach the scaling stage");

  a_bucket_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((PCT_W+1)'(out_bucket_r) * (PCT_W+1)'(10) <= (PCT_W+1)'(out_pct_r)
      && (PCT_W+1)'(out_pct_r) < (PCT_W+1)'(out_bucket_r) * (PCT_W+1)'(10) + (PCT_W+1)'(10)))
    else $error("bucket does not match percent");

  a_full_only_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((out_pct_r == PCT_W'(100)) == (out_mv_r >= CURVE_MV[0])))
    else $error("full charge reported off the top breakpoint");

  a_latch_moves_with_batch: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(s3_go) |-> $stable(latch_r))
    else $error("charging latch changed without a batch");

endmodule
